// File: rtl/tpoc_pkg.sv
// Package for the turning-path obstacle check: widths, constants, types and
// the small fixed-point helpers shared by the datapath modules.
// No dependencies.
package tpoc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_BITS  = 49;   // quotient bits of the radius divider
    localparam int SQ_BITS   = 33;   // root bits of the hypotenuse units
    localparam logic [31:0] RMAX = 32'(32767) << FRAC_BITS;

    typedef enum logic [1:0] {
        CFG_HALF_WIDTH = 2'd0,
        CFG_CTR_LENGTH = 2'd1,
        CFG_MARGIN     = 2'd2
    } t_cfg_idx;

    // object position carried beside the divider
    typedef struct packed {
        logic signed [27:0] x;
        logic        [23:0] y;
    } t_side;

    typedef struct packed {
        logic [48:0] num;
        logic [48:0] q;
        logic [27:0] rem;
        logic [27:0] den;
        logic        zero;
        t_side       side;
    } t_div_st;

    typedef struct packed {
        logic [65:0] op;
        logic [32:0] root;
        logic [34:0] rem;
    } t_sq_lane;

    // floor(v / 5), exact for 13-bit v
    function automatic logic [10:0] div5(input logic [12:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'(52429);
        return p[28:18];
    endfunction

    // floor(cm * 2^16 / 100) = cm*655 + floor(cm*9/25)
    function automatic logic [22:0] cm_to_fx(input logic [12:0] cm);
        logic [16:0] t;
        logic [34:0] p;
        t = 17'(cm) * 17'd9;
        p = 35'(t) * 35'(167773);
        return 23'(23'(cm) * 23'd655) + 23'(p[34:22]);
    endfunction

    // one digit of the restoring square root
    function automatic t_sq_lane sq_step(input t_sq_lane s);
        logic [36:0] rt;
        logic [36:0] trial;
        t_sq_lane    n;
        rt    = {s.rem, s.op[65:64]};
        trial = {2'b00, s.root, 2'b01};
        n.op  = {s.op[63:0], 2'b00};
        if (rt >= trial) begin
            n.rem  = 35'(rt - trial);
            n.root = {s.root[31:0], 1'b1};
        end else begin
            n.rem  = rt[34:0];
            n.root = {s.root[31:0], 1'b0};
        end
        return n;
    endfunction

endpackage

// File: rtl/turning_path_obstacle_check_top.sv
// Turning-path obstacle check, top level.
// Stages from accepted request to result: 1 divider setup, 49 divider bits,
// 1 clamp, 3 offset/square/sum stages, 1 root setup, 33 root bits, 1 out.
// Throughput: one request per cycle; the whole pipe holds while a result waits.
// Reset (synchronous, active low) clears all valid bits and loads the
// registers with 140 cm half width, 1000 cm centre length, 80 cm margin.
module turning_path_obstacle_check_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [12:0]        i_dist_long_raw,
    input  logic [10:0]        i_dist_lat_raw,
    input  logic signed [15:0] i_yaw_rate,
    input  logic [15:0]        i_vehicle_speed,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_in_path,
    // register writes
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [12:0]        i_cfg_wdata
);

    // ---- configuration registers and their Q16 forms ----
    logic [9:0]  r_hw_cm;
    logic [12:0] r_len_cm;
    logic [8:0]  r_mg_cm;
    logic [19:0] r_hw_fx;
    logic [22:0] r_len_fx;
    logic [18:0] r_mg_fx;
    logic [45:0] r_len_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw_cm  <= 10'd140;
            r_len_cm <= 13'd1000;
            r_mg_cm  <= 9'd80;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tpoc_pkg::CFG_HALF_WIDTH: r_hw_cm  <= i_cfg_wdata[9:0];
                tpoc_pkg::CFG_CTR_LENGTH: r_len_cm <= i_cfg_wdata;
                tpoc_pkg::CFG_MARGIN:     r_mg_cm  <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // user keeps registers static in traffic, unenforced; extra reg harmless
    logic [22:0] w_len_fx;
    assign w_len_fx = tpoc_pkg::cm_to_fx(r_len_cm);
    always_ff @(posedge i_clk) begin
        r_hw_fx  <= 20'(tpoc_pkg::cm_to_fx(13'(r_hw_cm)));
        r_len_fx <= w_len_fx;
        r_mg_fx  <= 19'(tpoc_pkg::cm_to_fx(13'(r_mg_cm)));
        r_len_sq <= 46'(r_len_fx) * 46'(r_len_fx);
    end

    // ---- global advance: the pipe moves unless a finished result is held ----
    logic r_out_vld;
    logic r_out_bit;
    logic w_en;
    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = !w_en;

    // ---- object position in Q16 metres ----
    // floor(raw*2^16/5) = raw*13107 + floor(raw/5)
    logic [10:0]     w_lat_off;
    logic [26:0]     w_x_pos;
    tpoc_pkg::t_side w_side;
    always_comb begin
        w_lat_off = (i_dist_lat_raw >= 11'd1023) ? 11'(i_dist_lat_raw - 11'd1023)
                                                 : 11'(11'd1023 - i_dist_lat_raw);
        w_x_pos   = 27'(27'(i_dist_long_raw) * 27'd13107) + 27'(tpoc_pkg::div5(i_dist_long_raw));
        w_side.x  = 28'(signed'({1'b0, w_x_pos}) - 28'sd32768000);
        w_side.y  = 24'(24'(w_lat_off) * 24'd13107) + 24'(tpoc_pkg::div5(13'(w_lat_off)));
    end

    // ---- turning radius ----
    logic            w_div_vld;
    logic [31:0]     w_rad;
    tpoc_pkg::t_side w_div_side;

    tpoc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_speed (i_vehicle_speed),
        .i_yaw   (i_yaw_rate),
        .i_side  (w_side),
        .o_valid (w_div_vld),
        .o_rad   (w_rad),
        .o_side  (w_div_side)
    );

    // ---- stage A: offsets from the turn centre and band edges ----
    logic signed [28:0] w_dx;
    logic signed [32:0] w_dy;
    logic               r_a_vld;
    logic [27:0]        r_a_dx;
    logic [31:0]        r_a_dy;
    logic [31:0]        r_a_s;
    logic signed [33:0] r_a_inr;

    always_comb begin
        w_dx = 29'({w_div_side.x[27], w_div_side.x}) + signed'({6'b0, r_len_fx});
        w_dy = signed'({1'b0, w_rad}) - signed'({9'b0, w_div_side.y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else if (w_en) r_a_vld <= w_div_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_dx  <= w_dx[28] ? 28'(-w_dx) : w_dx[27:0];
            r_a_dy  <= w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
            r_a_s   <= 32'(w_rad + 32'(r_hw_fx));
            r_a_inr <= signed'({2'b0, w_rad}) - signed'({14'b0, r_hw_fx});
        end
    end

    // ---- stage B: squares ----
    logic               r_b_vld;
    logic [55:0]        r_b_dx2;
    logic [63:0]        r_b_dy2;
    logic [63:0]        r_b_s2;
    logic signed [33:0] r_b_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else if (w_en) r_b_vld <= r_a_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_dx2 <= 56'(r_a_dx) * 56'(r_a_dx);
            r_b_dy2 <= 64'(r_a_dy) * 64'(r_a_dy);
            r_b_s2  <= 64'(r_a_s) * 64'(r_a_s);
            r_b_inr <= r_a_inr;
        end
    end

    // ---- stage C: sums of squares ----
    logic               r_c_vld;
    logic [64:0]        r_c_dist2;
    logic [64:0]        r_c_out2;
    logic signed [33:0] r_c_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_vld <= 1'b0;
        else if (w_en) r_c_vld <= r_b_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_dist2 <= 65'(r_b_dx2) + 65'(r_b_dy2);
            r_c_out2  <= 65'(r_b_s2) + 65'(r_len_sq);
            r_c_inr   <= r_b_inr;
        end
    end

    // ---- object distance and outer radius ----
    logic               w_hyp_vld;
    logic [32:0]        w_dist;
    logic [32:0]        w_outer;
    logic signed [33:0] w_inner;

    tpoc_hyp u_hyp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_c_vld),
        .i_sq_a   (r_c_dist2),
        .i_sq_b   (r_c_out2),
        .i_inner  (r_c_inr),
        .o_valid  (w_hyp_vld),
        .o_root_a (w_dist),
        .o_root_b (w_outer),
        .o_inner  (w_inner)
    );

    // ---- band test into the output register ----
    // an empty band (margin too wide) fails at least one side naturally
    logic signed [35:0] w_hi;
    logic signed [35:0] w_lo;
    logic signed [35:0] w_d;
    always_comb begin
        w_d  = signed'({3'b0, w_dist});
        w_hi = signed'({3'b0, w_outer}) - signed'({17'b0, r_mg_fx});
        w_lo = 36'({{2{w_inner[33]}}, w_inner}) + signed'({17'b0, r_mg_fx});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (w_en) r_out_vld <= w_hyp_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_out_bit <= (w_d < w_hi) && (w_d > w_lo);
    end

    assign o_valid   = r_out_vld;
    assign o_in_path = r_out_bit;

    // ---- assertions ----
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_vld)
        else $error("request stalled with empty output register");

    a_rad_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_vld |-> (w_rad <= tpoc_pkg::RMAX))
        else $error("turning radius above clamp");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> (r_out_vld && $stable(r_out_bit) && $stable(r_c_vld)))
        else $error("pipeline moved while result held");

endmodule

// File: rtl/tpoc_div.sv
// Pipelined radius divider: R = speed*75000*2^16 / (5181*|yaw|), saturated.
// One quotient bit per stage. Depends on tpoc_pkg.
module tpoc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [15:0]         i_speed,
    input  logic signed [15:0]  i_yaw,
    input  tpoc_pkg::t_side     i_side,
    output logic                o_valid,
    output logic [31:0]         o_rad,
    output tpoc_pkg::t_side     o_side
);

    tpoc_pkg::t_div_st r_st  [0:tpoc_pkg::DIV_BITS];
    logic              r_vld [0:tpoc_pkg::DIV_BITS];
    tpoc_pkg::t_div_st n_st0;
    logic [15:0]       w_ymag;
    logic [32:0]       w_prod;
    logic [31:0]       r_rad;
    tpoc_pkg::t_side   r_side;
    logic              r_ovld;

    always_comb begin
        w_ymag     = i_yaw[15] ? 16'(-i_yaw) : 16'(i_yaw);
        w_prod     = 33'(i_speed) * 33'(75000);
        n_st0.num  = {w_prod, {tpoc_pkg::FRAC_BITS{1'b0}}};
        n_st0.q    = '0;
        n_st0.rem  = '0;
        n_st0.den  = 28'(w_ymag) * 28'(5181);
        n_st0.zero = (w_ymag == 16'd0);
        n_st0.side = i_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld[0] <= 1'b0;
        else if (i_en) r_vld[0] <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) r_st[0] <= n_st0;
    end

    for (genvar k = 0; k < tpoc_pkg::DIV_BITS; k++) begin : g_stage
        logic [28:0]       w_rt;
        logic              w_ge;
        tpoc_pkg::t_div_st w_nx;
        always_comb begin
            w_rt      = {r_st[k].rem, r_st[k].num[48]};
            w_ge      = w_rt >= {1'b0, r_st[k].den};
            w_nx      = r_st[k];
            w_nx.num  = {r_st[k].num[47:0], 1'b0};
            w_nx.q    = {r_st[k].q[47:0], w_ge};
            w_nx.rem  = w_ge ? 28'(w_rt - {1'b0, r_st[k].den}) : w_rt[27:0];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[k+1] <= 1'b0;
            else if (i_en) r_vld[k+1] <= r_vld[k];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) r_st[k+1] <= w_nx;
        end
    end

    // zero yaw gives zero radius; large quotients clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (i_en) r_ovld <= r_vld[tpoc_pkg::DIV_BITS];
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= r_st[tpoc_pkg::DIV_BITS].side;
            if (r_st[tpoc_pkg::DIV_BITS].zero) r_rad <= '0;
            else if (r_st[tpoc_pkg::DIV_BITS].q > 49'(tpoc_pkg::RMAX)) r_rad <= tpoc_pkg::RMAX;
            else r_rad <= r_st[tpoc_pkg::DIV_BITS].q[31:0];
        end
    end

    assign o_valid = r_ovld;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

// File: rtl/tpoc_hyp.sv
// Two-lane pipelined integer square root, one root bit per stage, with the
// inner radius carried alongside. Depends on tpoc_pkg.
module tpoc_hyp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [64:0]        i_sq_a,
    input  logic [64:0]        i_sq_b,
    input  logic signed [33:0] i_inner,
    output logic               o_valid,
    output logic [32:0]        o_root_a,
    output logic [32:0]        o_root_b,
    output logic signed [33:0] o_inner
);

    tpoc_pkg::t_sq_lane r_a   [0:tpoc_pkg::SQ_BITS];
    tpoc_pkg::t_sq_lane r_b   [0:tpoc_pkg::SQ_BITS];
    logic signed [33:0] r_inr [0:tpoc_pkg::SQ_BITS];
    logic               r_vld [0:tpoc_pkg::SQ_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld[0] <= 1'b0;
        else if (i_en) r_vld[0] <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0]   <= '{op: {1'b0, i_sq_a}, root: '0, rem: '0};
            r_b[0]   <= '{op: {1'b0, i_sq_b}, root: '0, rem: '0};
            r_inr[0] <= i_inner;
        end
    end

    for (genvar k = 0; k < tpoc_pkg::SQ_BITS; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[k+1] <= 1'b0;
            else if (i_en) r_vld[k+1] <= r_vld[k];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k+1]   <= tpoc_pkg::sq_step(r_a[k]);
                r_b[k+1]   <= tpoc_pkg::sq_step(r_b[k]);
                r_inr[k+1] <= r_inr[k];
            end
        end
    end

    assign o_valid  = r_vld[tpoc_pkg::SQ_BITS];
    assign o_root_a = r_a[tpoc_pkg::SQ_BITS].root;
    assign o_root_b = r_b[tpoc_pkg::SQ_BITS].root;
    assign o_inner  = r_inr[tpoc_pkg::SQ_BITS];

endmodule
